// ----- hdl/pib_pkg.sv -----
package pib_pkg;

	localparam int MAX_COLORS_DEF = 256;
	localparam logic [7:0] ALPHA_LIMIT = 8'd127;
	localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
	localparam int OUT_W = 9;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       start_image;
	} pixel_t;

	typedef struct packed {
		logic [OUT_W-1:0] color_index;
		logic             new_color;
		logic             overflow;
		logic [OUT_W-1:0] colors_in_use;
	} result_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic finish;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic opaque;
		logic hit;
		logic scan_end;
		logic res_busy;
	} status_t;

endpackage

// ----- hdl/palette_index_builder_top.sv -----
// flow: a request loads the pixel, then the color table is scanned (a transparent pixel
// ends the scan without a compare, a match ends it, a new color scans every stored entry),
// then the result moves to the output register; the color table is read one entry per cycle
// throughput: one pixel in flight, the next request is taken once the result
// has moved to the output register
// reset: arst_n clears the state, empties the table count and sets alpha_present
module palette_index_builder_top #(
	parameter int MAX_COLORS = pib_pkg::MAX_COLORS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_wdata,
	input  logic              pix_valid,
	output logic              pix_stall,
	input  pib_pkg::pixel_t   pix,
	output logic              res_valid,
	input  logic              res_stall,
	output pib_pkg::result_t  res
);

	pib_pkg::cmd_t    cmd;
	pib_pkg::status_t status;

	pib_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.status   (status),
		.cmd      (cmd)
	);

	pib_datapath #(
		.MAX_COLORS(MAX_COLORS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix      (pix),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.cmd      (cmd),
		.status   (status),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

endmodule

// ----- hdl/pib_ram.sv -----
module pib_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hdl/pib_ctrl.sv -----
module pib_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pix_valid,
	output logic                  pix_stall,
	input  pib_pkg::status_t      status,
	output pib_pkg::cmd_t         cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign pix_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (pix_valid) begin
					cmd.load = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (!status.opaque || status.hit || status.scan_end) begin
					cmd.finish = 1'b1;
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!status.res_busy) begin
					cmd.emit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- hdl/pib_datapath.sv -----
module pib_datapath #(
	parameter int MAX_COLORS = pib_pkg::MAX_COLORS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pib_pkg::pixel_t     pix,
	input  logic                cfg_we,
	input  logic                cfg_wdata,
	input  pib_pkg::cmd_t       cmd,
	output pib_pkg::status_t    status,
	output logic                res_valid,
	input  logic                res_stall,
	output pib_pkg::result_t    res
);

	localparam int IW = $clog2(MAX_COLORS);
	localparam int CW = $clog2(MAX_COLORS + 1);
	localparam int OW = pib_pkg::OUT_W;

	logic              alpha_present_q;
	logic [23:0]       rgb_q;
	logic              opaque_q;
	logic [CW-1:0]     used_q;
	logic [CW-1:0]     scan_q;
	logic [CW-1:0]     cmp_idx_q;
	logic              cmp_vld_q;
	logic [23:0]       rdata;
	logic              hit;
	logic              full;
	logic              tbl_we;
	logic [7:0]        alpha_eff;
	logic [CW-1:0]     used_next;
	logic [CW-1:0]     idx_next;
	logic [CW+OW-1:0]  idx_wide;
	logic [CW+OW-1:0]  used_wide;
	pib_pkg::result_t  result_q;
	pib_pkg::result_t  result_d;
	logic              res_valid_q;
	pib_pkg::result_t  res_q;

	assign alpha_eff = alpha_present_q ? pix.alpha : pib_pkg::ALPHA_OPAQUE;
	assign hit = cmp_vld_q && (rdata == rgb_q);
	assign full = (used_q == CW'(MAX_COLORS));

	assign status.opaque = opaque_q;
	assign status.hit = hit;
	assign status.scan_end = (scan_q >= used_q) && !cmp_vld_q;
	assign status.res_busy = res_valid_q && res_stall;

	// table write only on a miss for an opaque pixel with room left
	assign tbl_we = cmd.finish && opaque_q && !hit && !full;

	always_comb begin
		used_next = used_q;
		idx_next = '0;
		result_d = '0;
		if (opaque_q) begin
			if (hit) begin
				idx_next = cmp_idx_q + CW'(1);
			end else if (full) begin
				result_d.overflow = 1'b1;
			end else begin
				idx_next = used_q + CW'(1);
				used_next = used_q + CW'(1);
				result_d.new_color = 1'b1;
			end
		end
		idx_wide = {{OW{1'b0}}, idx_next};
		used_wide = {{OW{1'b0}}, used_next};
		result_d.color_index = idx_wide[OW-1:0];
		result_d.colors_in_use = used_wide[OW-1:0];
	end

	pib_ram #(
		.WIDTH(24),
		.DEPTH(MAX_COLORS)
	) u_table (
		.clk  (clk),
		.we   (tbl_we),
		.waddr(used_q[IW-1:0]),
		.wdata(rgb_q),
		.raddr(scan_q[IW-1:0]),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_present_q <= 1'b1;
			used_q <= '0;
			scan_q <= '0;
			cmp_vld_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				alpha_present_q <= cfg_wdata;
			end
			if (cmd.load) begin
				scan_q <= '0;
				cmp_vld_q <= 1'b0;
				if (pix.start_image) begin
					used_q <= '0;
				end
			end else if (cmd.scan) begin
				// read one entry a cycle, compare it the cycle after
				if (scan_q < used_q) begin
					scan_q <= scan_q + CW'(1);
					cmp_vld_q <= 1'b1;
				end else begin
					cmp_vld_q <= 1'b0;
				end
			end
			if (cmd.finish) begin
				used_q <= used_next;
			end
			if (cmd.emit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rgb_q <= {pix.red, pix.green, pix.blue};
			opaque_q <= (alpha_eff >= pib_pkg::ALPHA_LIMIT);
		end
		if (cmd.scan) begin
			cmp_idx_q <= scan_q;
		end
		if (cmd.finish) begin
			result_q <= result_d;
		end
		if (cmd.emit) begin
			res_q <= result_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

endmodule

// ----- hdl/pib_checker.sv -----
module pib_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              pix_valid,
	input logic              pix_stall,
	input pib_pkg::result_t  res,
	input logic              res_valid,
	input logic              res_stall
);

	// a held result stays put
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// one pixel in flight: a request is never followed by another at once
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_stall |=> pix_stall)
		else $error("request taken while busy");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res.new_color && res.overflow))
		else $error("new color and overflow together");

	// a new entry gets the last index in use
	a_new_index: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.new_color |-> res.color_index == res.colors_in_use)
		else $error("new color index mismatch");

	a_overflow_index: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.overflow |-> res.color_index == '0)
		else $error("overflow with nonzero index");

endmodule

bind palette_index_builder_top pib_checker u_pib_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.pix_valid(pix_valid),
	.pix_stall(pix_stall),
	.res      (res),
	.res_valid(res_valid),
	.res_stall(res_stall)
);
